### rtl/kcp_pkg.sv
// ----------------------------------------------------------------------------
// kcp_pkg
// Shared constants and types for the k-core peeling order block.
// ----------------------------------------------------------------------------
`default_nettype none

package kcp_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_ADJ      = 8192;
    localparam int VID_W        = 10;
    localparam int CNT_W        = 11;
    localparam int START_W      = 14;
    localparam int EIDX_W       = 13;

    localparam logic [1:0] ACT_LOAD_VERTEX = 2'd0;
    localparam logic [1:0] ACT_LOAD_ADJ    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE     = 2'd2;
    localparam logic [1:0] ACT_QUERY       = 2'd3;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    // register byte addresses
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

    typedef struct packed {
        logic [1:0]         action;
        logic [VID_W-1:0]   vertex_id;
        logic [START_W-1:0] adjacency_start;
        logic [VID_W-1:0]   vertex_degree;
        logic [EIDX_W-1:0]  entry_index;
        logic [VID_W-1:0]   neighbor_id;
    } item_t;

    typedef struct packed {
        logic               result_kind;
        logic [VID_W-1:0]   vertex_id_out;
        logic [VID_W-1:0]   core_number;
        logic [CNT_W-1:0]   listing_order;
        logic [VID_W-1:0]   max_core;
    } result_t;

endpackage

`default_nettype wire

### rtl/kcp_ram.sv
// ----------------------------------------------------------------------------
// kcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/kcp_engine.sv
// ----------------------------------------------------------------------------
// kcp_engine
// Graph stores and the sequencer that runs bin-sort core peeling.
// ----------------------------------------------------------------------------
`default_nettype none

module kcp_engine (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    input  wire kcp_pkg::item_t            item,
    output logic                           ready,
    input  wire logic [kcp_pkg::CNT_W-1:0] used_n,
    output logic                           res_valid,
    output kcp_pkg::result_t               res,
    input  wire logic                      res_take
);
    import kcp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_CNT_A, S_CNT_B, S_CNT_C, S_PF_A, S_PF_B,
        S_PL_A, S_PL_B, S_PL_C, S_PE_A, S_PE_B, S_PE_C,
        S_NB_A, S_NB_B, S_NB_C, S_NB_D, S_NB_E, S_NB_F,
        S_MX_A, S_MX_B, S_Q, S_EMIT
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0]   idx_reg, sum_reg, n_reg, k_reg;
    logic [VID_W-1:0]   d_reg, cur_reg, dv_reg, cnt_reg, u_reg, du_reg;
    logic [VID_W-1:0]   pu_reg, pw_reg, w_reg, maxc_reg;
    logic [START_W-1:0] base_reg;
    logic               kind_reg;
    logic [VID_W-1:0]   rvid_reg, rcore_reg;
    logic [CNT_W-1:0]   rorder_reg;

    // memory ports
    logic deg_we, start_we, nbr_we, bin_we, pos_we, sort_we, core_we, ord_we;
    logic [VID_W-1:0]   deg_wa, start_wa, bin_wa, pos_wa, sort_wa, core_wa, ord_wa;
    logic [VID_W-1:0]   deg_ra, start_ra, bin_ra, pos_ra, sort_ra, core_ra, ord_ra;
    logic [EIDX_W-1:0]  nbr_wa, nbr_ra;
    logic [VID_W-1:0]   deg_wd, nbr_wd, pos_wd, sort_wd, core_wd;
    logic [START_W-1:0] start_wd;
    logic [CNT_W-1:0]   bin_wd, ord_wd;
    logic [VID_W-1:0]   deg_rd, nbr_rd, pos_rd, sort_rd, core_rd;
    logic [START_W-1:0] start_rd;
    logic [CNT_W-1:0]   bin_rd, ord_rd;

    logic               accept;
    logic [START_W:0]   j_sum;
    logic [CNT_W-1:0]   pf_sum, pl_pos;

    assign ready  = (state_reg == S_IDLE);
    assign accept = ready && item_valid;
    assign j_sum  = {1'b0, base_reg} + {{(START_W-CNT_W+1){1'b0}}, k_reg};
    assign pf_sum = sum_reg + bin_rd;
    assign pl_pos = bin_rd - 11'd1;

    kcp_ram #(.WIDTH(VID_W),   .DEPTH(MAX_VERTICES)) u_deg   (.clk(clk), .we(deg_we),
        .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd));
    kcp_ram #(.WIDTH(START_W), .DEPTH(MAX_VERTICES)) u_start (.clk(clk), .we(start_we),
        .waddr(start_wa), .wdata(start_wd), .raddr(start_ra), .rdata(start_rd));
    kcp_ram #(.WIDTH(VID_W),   .DEPTH(MAX_ADJ))      u_nbr   (.clk(clk), .we(nbr_we),
        .waddr(nbr_wa), .wdata(nbr_wd), .raddr(nbr_ra), .rdata(nbr_rd));
    kcp_ram #(.WIDTH(CNT_W),   .DEPTH(MAX_VERTICES)) u_bin   (.clk(clk), .we(bin_we),
        .waddr(bin_wa), .wdata(bin_wd), .raddr(bin_ra), .rdata(bin_rd));
    kcp_ram #(.WIDTH(VID_W),   .DEPTH(MAX_VERTICES)) u_pos   (.clk(clk), .we(pos_we),
        .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd));
    kcp_ram #(.WIDTH(VID_W),   .DEPTH(MAX_VERTICES)) u_sort  (.clk(clk), .we(sort_we),
        .waddr(sort_wa), .wdata(sort_wd), .raddr(sort_ra), .rdata(sort_rd));
    kcp_ram #(.WIDTH(VID_W),   .DEPTH(MAX_VERTICES)) u_core  (.clk(clk), .we(core_we),
        .waddr(core_wa), .wdata(core_wd), .raddr(core_ra), .rdata(core_rd));
    kcp_ram #(.WIDTH(CNT_W),   .DEPTH(MAX_VERTICES)) u_ord   (.clk(clk), .we(ord_we),
        .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));

    // drive memory ports from the current step
    always_comb
    begin
        deg_we = 1'b0; start_we = 1'b0; nbr_we = 1'b0; bin_we = 1'b0;
        pos_we = 1'b0; sort_we = 1'b0; core_we = 1'b0; ord_we = 1'b0;
        deg_wa = item.vertex_id; deg_wd = item.vertex_degree;
        start_wa = item.vertex_id; start_wd = item.adjacency_start;
        nbr_wa = item.entry_index; nbr_wd = item.neighbor_id;
        bin_wa = idx_reg[VID_W-1:0]; bin_wd = '0;
        pos_wa = u_reg; pos_wd = pw_reg;
        sort_wa = pu_reg; sort_wd = sort_rd;
        core_wa = idx_reg[VID_W-1:0]; core_wd = deg_rd;
        ord_wa = sort_rd; ord_wd = n_reg - idx_reg;
        deg_ra = idx_reg[VID_W-1:0]; start_ra = cur_reg; nbr_ra = j_sum[EIDX_W-1:0];
        bin_ra = idx_reg[VID_W-1:0]; pos_ra = nbr_rd; sort_ra = idx_reg[VID_W-1:0];
        core_ra = idx_reg[VID_W-1:0]; ord_ra = item.vertex_id;
        case (state_reg)
            S_IDLE:
            begin
                core_ra = item.vertex_id;
                if (accept && item.action == ACT_LOAD_VERTEX)
                begin
                    deg_we = 1'b1;
                    start_we = 1'b1;
                end
                if (accept && item.action == ACT_LOAD_ADJ)
                begin
                    nbr_we = 1'b1;
                end
            end
            S_CLR:
            begin
                bin_we = 1'b1;
            end
            S_CNT_B:
            begin
                core_we = 1'b1;
                bin_ra = deg_rd;
            end
            S_CNT_C:
            begin
                bin_we = 1'b1;
                bin_wa = d_reg;
                bin_wd = bin_rd + 11'd1;
            end
            S_PF_B:
            begin
                bin_we = 1'b1;
                bin_wd = pf_sum;
            end
            S_PL_B:
            begin
                bin_ra = core_rd;
            end
            S_PL_C:
            begin
                bin_we = 1'b1;
                bin_wa = d_reg;
                bin_wd = pl_pos;
                pos_we = 1'b1;
                pos_wa = idx_reg[VID_W-1:0];
                pos_wd = pl_pos[VID_W-1:0];
                sort_we = 1'b1;
                sort_wa = pl_pos[VID_W-1:0];
                sort_wd = idx_reg[VID_W-1:0];
            end
            S_PE_B:
            begin
                core_ra = sort_rd;
                start_ra = sort_rd;
                deg_ra = sort_rd;
                ord_we = 1'b1;
            end
            S_NB_B:
            begin
                core_ra = nbr_rd;
            end
            S_NB_C:
            begin
                bin_ra = core_rd;
            end
            S_NB_D:
            begin
                sort_ra = bin_rd[VID_W-1:0];
            end
            S_NB_E:
            begin
                if (sort_rd != u_reg)
                begin
                    pos_we = 1'b1;
                    sort_we = 1'b1;
                end
            end
            S_NB_F:
            begin
                if (w_reg != u_reg)
                begin
                    pos_we = 1'b1;
                    pos_wa = w_reg;
                    pos_wd = pu_reg;
                    sort_we = 1'b1;
                    sort_wa = pw_reg;
                    sort_wd = u_reg;
                end
                bin_we = 1'b1;
                bin_wa = du_reg;
                bin_wd = {1'b0, pw_reg} + 11'd1;
                core_we = 1'b1;
                core_wa = u_reg;
                core_wd = du_reg - 10'd1;
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
            maxc_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && item.action == ACT_COMPUTE)
                    begin
                        idx_reg   <= '0;
                        n_reg     <= used_n;
                        state_reg <= S_CLR;
                    end
                    else if (accept && item.action == ACT_QUERY)
                    begin
                        rvid_reg  <= item.vertex_id;
                        state_reg <= S_Q;
                    end
                end
                S_CLR:
                begin
                    idx_reg <= idx_reg + 11'd1;
                    if (idx_reg == 11'(MAX_VERTICES - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CNT_A;
                    end
                end
                S_CNT_A:
                begin
                    if (idx_reg == n_reg)
                    begin
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_PF_A;
                    end
                    else
                    begin
                        state_reg <= S_CNT_B;
                    end
                end
                S_CNT_B:
                begin
                    d_reg     <= deg_rd;
                    state_reg <= S_CNT_C;
                end
                S_CNT_C:
                begin
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_CNT_A;
                end
                S_PF_A:
                begin
                    if (idx_reg == 11'(MAX_VERTICES))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_PL_A;
                    end
                    else
                    begin
                        state_reg <= S_PF_B;
                    end
                end
                S_PF_B:
                begin
                    sum_reg   <= pf_sum;
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_PF_A;
                end
                S_PL_A:
                begin
                    if (idx_reg == n_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_PE_A;
                    end
                    else
                    begin
                        state_reg <= S_PL_B;
                    end
                end
                S_PL_B:
                begin
                    d_reg     <= core_rd;
                    state_reg <= S_PL_C;
                end
                S_PL_C:
                begin
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_PL_A;
                end
                S_PE_A:
                begin
                    if (idx_reg == n_reg)
                    begin
                        idx_reg   <= '0;
                        maxc_reg  <= '0;
                        state_reg <= S_MX_A;
                    end
                    else
                    begin
                        state_reg <= S_PE_B;
                    end
                end
                S_PE_B:
                begin
                    cur_reg   <= sort_rd;
                    state_reg <= S_PE_C;
                end
                S_PE_C:
                begin
                    dv_reg    <= core_rd;
                    base_reg  <= start_rd;
                    cnt_reg   <= deg_rd;
                    k_reg     <= '0;
                    state_reg <= S_NB_A;
                end
                S_NB_A:
                begin
                    if (k_reg == {1'b0, cnt_reg})
                    begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= S_PE_A;
                    end
                    else if (j_sum[START_W:EIDX_W] != '0)
                    begin
                        // skip positions past the adjacency store
                        k_reg <= k_reg + 11'd1;
                    end
                    else
                    begin
                        state_reg <= S_NB_B;
                    end
                end
                S_NB_B:
                begin
                    u_reg <= nbr_rd;
                    if ({1'b0, nbr_rd} >= n_reg)
                    begin
                        k_reg     <= k_reg + 11'd1;
                        state_reg <= S_NB_A;
                    end
                    else
                    begin
                        state_reg <= S_NB_C;
                    end
                end
                S_NB_C:
                begin
                    du_reg <= core_rd;
                    pu_reg <= pos_rd;
                    if (core_rd <= dv_reg)
                    begin
                        k_reg     <= k_reg + 11'd1;
                        state_reg <= S_NB_A;
                    end
                    else
                    begin
                        state_reg <= S_NB_D;
                    end
                end
                S_NB_D:
                begin
                    pw_reg    <= bin_rd[VID_W-1:0];
                    state_reg <= S_NB_E;
                end
                S_NB_E:
                begin
                    w_reg     <= sort_rd;
                    state_reg <= S_NB_F;
                end
                S_NB_F:
                begin
                    k_reg     <= k_reg + 11'd1;
                    state_reg <= S_NB_A;
                end
                S_MX_A:
                begin
                    if (idx_reg == n_reg)
                    begin
                        kind_reg   <= KIND_SUMMARY;
                        rvid_reg   <= '0;
                        rcore_reg  <= '0;
                        rorder_reg <= '0;
                        state_reg  <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_MX_B;
                    end
                end
                S_MX_B:
                begin
                    if (core_rd > maxc_reg)
                    begin
                        maxc_reg <= core_rd;
                    end
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_MX_A;
                end
                S_Q:
                begin
                    kind_reg <= KIND_QUERY;
                    if ({1'b0, rvid_reg} < used_n)
                    begin
                        rcore_reg  <= core_rd;
                        rorder_reg <= ord_rd;
                    end
                    else
                    begin
                        rcore_reg  <= '0;
                        rorder_reg <= '0;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = (state_reg == S_EMIT);
    assign res = '{result_kind: kind_reg, vertex_id_out: rvid_reg, core_number: rcore_reg,
                   listing_order: rorder_reg, max_core: maxc_reg};

    // peel loops never run past the vertex count
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PE_B || state_reg == S_PL_B || state_reg == S_CNT_B)
        |-> idx_reg < n_reg)
        else $error("loop index past vertex count");

    // only neighbors of higher degree are moved and decremented
    a_dec_higher: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB_F) |-> du_reg > dv_reg)
        else $error("decrement of non-higher neighbor");

    // a compute item starts with the bin clear sweep
    a_compute_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.action == ACT_COMPUTE) |=> state_reg == S_CLR)
        else $error("compute did not start clear");

    // neighbor walk stays within the degree of the current vertex
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB_B) |-> k_reg < {1'b0, cnt_reg})
        else $error("neighbor index past degree");

endmodule

`default_nettype wire

### rtl/k_core_peeling_order_top.sv
// ----------------------------------------------------------------------------
// k_core_peeling_order_top
// k-core decomposition by bin-sort peeling, with an APB register and an
// output register toward the result channel.
// ----------------------------------------------------------------------------
// Loads are written to the graph stores on accept and return no result. A
// query reads its core and order, then passes the emit state and the output
// register. A compute runs the single sequencer through clear, count, prefix,
// place, peel and max sweeps over registered-read RAMs. One item is worked
// at a time; after a compute or query the input is stalled until its result
// enters the output register. Reset clears control state and sets vertex_count
// to 1; the graph stores hold no reset value and get no clearing pass.
`default_nettype none

module k_core_peeling_order_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [9:0]  vertex_id,
    input  wire logic [13:0] adjacency_start,
    input  wire logic [9:0]  vertex_degree,
    input  wire logic [12:0] entry_index,
    input  wire logic [9:0]  neighbor_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic      [9:0]  vertex_id_out,
    output logic      [9:0]  core_number,
    output logic      [10:0] listing_order,
    output logic      [9:0]  max_core
);
    import kcp_pkg::*;

    logic [CNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0] used_n;
    logic             ready, res_valid, res_take, out_valid_reg;
    result_t          res, out_reg;
    item_t            item;

    // register write and read-back
    assign pready = 1'b1;
    assign prdata = {21'd0, vcount_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 11'd1;
        end
        else if (psel && penable && pwrite && paddr == REG_VERTEX_COUNT)
        begin
            vcount_reg <= pwdata[CNT_W-1:0];
        end
    end

    // clamp the vertex count to the store depth
    assign used_n = (vcount_reg > 11'(MAX_VERTICES)) ? 11'(MAX_VERTICES) : vcount_reg;

    assign item = '{action: action, vertex_id: vertex_id, adjacency_start: adjacency_start,
                    vertex_degree: vertex_degree, entry_index: entry_index,
                    neighbor_id: neighbor_id};
    assign in_stall = !ready;

    kcp_engine u_engine (
        .clk(clk), .rst_n(rst_n), .item_valid(in_valid), .item(item), .ready(ready),
        .used_n(used_n), .res_valid(res_valid), .res(res), .res_take(res_take)
    );

    // output register: load when empty or being taken
    assign res_take = !out_valid_reg || !out_stall;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = out_reg.result_kind;
    assign vertex_id_out = out_reg.vertex_id_out;
    assign core_number   = out_reg.core_number;
    assign listing_order = out_reg.listing_order;
    assign max_core      = out_reg.max_core;

endmodule

`default_nettype wire

### bench/k_core_peeling_order_top_tb.sv
// ----------------------------------------------------------------------------
// k_core_peeling_order_top_tb
// Loads random graphs in adjacency form, runs core peeling and queries random
// vertices' core and listing order. A scoreboard peels its own copy of the
// graph and checks each result field by field. Both channels idle and stall
// at random, and vertex_count is set between graphs.
// ----------------------------------------------------------------------------
`default_nettype none

module k_core_peeling_order_top_tb;

    import kcp_pkg::*;

    // Keep a copy of the graph, peel it on compute and queue the answers.
    class peel_scoreboard;
        logic [9:0]  degree_of [MAX_VERTICES];
        logic [13:0] start_of [MAX_VERTICES];
        logic [9:0]  neighbor_at [MAX_ADJ];
        int          core_of [MAX_VERTICES];
        int          order_of [MAX_VERTICES];
        int          slot_of [MAX_VERTICES];
        int          by_degree [MAX_VERTICES];
        int          bin_head [MAX_VERTICES];
        int          top_core;
        int          vertex_total;
        int          errors;
        int          checked;
        result_t     awaited_results[$];

        function new();
            vertex_total = 1;
            top_core = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int used_vertices();
            return (vertex_total > MAX_VERTICES) ? MAX_VERTICES : vertex_total;
        endfunction

        // Bin-sort the vertices by degree and peel from the lowest degree.
        function void peel_graph();
            int n;
            int sum;
            int p;
            int cur;
            int dv;
            int j;
            int u;
            int du;
            int pu;
            int pw;
            int w;
            n = used_vertices();
            sum = 0;
            for (int d = 0; d < MAX_VERTICES; d++)
                bin_head[d] = 0;
            for (int v = 0; v < n; v++)
            begin
                core_of[v] = degree_of[v];
                bin_head[core_of[v]]++;
            end
            for (int d = 0; d < MAX_VERTICES; d++)
            begin
                sum += bin_head[d];
                bin_head[d] = sum;
            end
            for (int v = 0; v < n; v++)
            begin
                bin_head[core_of[v]]--;
                p = bin_head[core_of[v]];
                slot_of[v] = p;
                by_degree[p] = v;
            end
            for (int i = 0; i < n; i++)
            begin
                cur = by_degree[i];
                dv = core_of[cur];
                order_of[cur] = n - i;
                for (int k = 0; k < degree_of[cur]; k++)
                begin
                    j = start_of[cur] + k;
                    if (j >= MAX_ADJ)
                        continue;
                    u = neighbor_at[j];
                    if (u >= n)
                        continue;
                    du = core_of[u];
                    if (du <= dv)
                        continue;
                    pu = slot_of[u];
                    pw = bin_head[du];
                    w = by_degree[pw];
                    if (u != w)
                    begin
                        slot_of[u] = pw;
                        by_degree[pu] = w;
                        slot_of[w] = pu;
                        by_degree[pw] = u;
                    end
                    bin_head[du]++;
                    core_of[u] = du - 1;
                end
            end
            top_core = 0;
            for (int v = 0; v < n; v++)
                if (core_of[v] > top_core)
                    top_core = core_of[v];
        endfunction

        function void note_item(item_t it);
            result_t r;
            r = '0;
            case (it.action)
                ACT_LOAD_VERTEX:
                begin
                    start_of[it.vertex_id] = it.adjacency_start;
                    degree_of[it.vertex_id] = it.vertex_degree;
                end
                ACT_LOAD_ADJ:
                    neighbor_at[it.entry_index] = it.neighbor_id;
                ACT_COMPUTE:
                begin
                    peel_graph();
                    r.result_kind = KIND_SUMMARY;
                    r.max_core = top_core[9:0];
                    awaited_results.push_back(r);
                end
                default:
                begin
                    r.result_kind = KIND_QUERY;
                    r.vertex_id_out = it.vertex_id;
                    if (it.vertex_id < used_vertices())
                    begin
                        r.core_number = core_of[it.vertex_id][9:0];
                        r.listing_order = order_of[it.vertex_id][10:0];
                    end
                    r.max_core = top_core[9:0];
                    awaited_results.push_back(r);
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (awaited_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing awaited: %p", $time, got);
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                errors++;
                $display("%0t: result_kind expected %0d got %0d", $time,
                         want.result_kind, got.result_kind);
            end
            if (got.vertex_id_out !== want.vertex_id_out)
            begin
                errors++;
                $display("%0t: vertex_id_out expected %0d got %0d", $time,
                         want.vertex_id_out, got.vertex_id_out);
            end
            if (got.core_number !== want.core_number)
            begin
                errors++;
                $display("%0t: core_number expected %0d got %0d", $time,
                         want.core_number, got.core_number);
            end
            if (got.listing_order !== want.listing_order)
            begin
                errors++;
                $display("%0t: listing_order expected %0d got %0d", $time,
                         want.listing_order, got.listing_order);
            end
            if (got.max_core !== want.max_core)
            begin
                errors++;
                $display("%0t: max_core expected %0d got %0d", $time,
                         want.max_core, got.max_core);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic [9:0]  vertex_id = '0;
    logic [13:0] adjacency_start = '0;
    logic [9:0]  vertex_degree = '0;
    logic [12:0] entry_index = '0;
    logic [9:0]  neighbor_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [9:0]  vertex_id_out;
    logic [9:0]  core_number;
    logic [10:0] listing_order;
    logic [9:0]  max_core;

    peel_scoreboard sb = new();

    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      items_sent = 0;
    int      computes_sent = 0;
    logic    out_take = 1'b0;
    result_t out_seen = '0;

    k_core_peeling_order_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .vertex_id(vertex_id), .adjacency_start(adjacency_start),
        .vertex_degree(vertex_degree), .entry_index(entry_index),
        .neighbor_id(neighbor_id),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .vertex_id_out(vertex_id_out),
        .core_number(core_number), .listing_order(listing_order),
        .max_core(max_core)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sample the result channel mid-cycle; the following edge takes it.
    always @(negedge clk)
    begin
        out_take <= rst_n && out_valid && !out_stall;
        out_seen <= {result_kind, vertex_id_out, core_number, listing_order, max_core};
    end

    // Check taken results and drive the receiver stall.
    always @(posedge clk)
    begin
        if (out_take)
            sb.check_result(out_seen);
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Pick one of the idling modes.
    task automatic set_mode(int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    function automatic item_t noise_item(logic [1:0] act);
        item_t it;
        it.action = act;
        it.vertex_id = 10'($urandom_range(0, 1023));
        it.adjacency_start = 14'($urandom_range(0, 8192));
        it.vertex_degree = 10'($urandom_range(0, 1023));
        it.entry_index = 13'($urandom_range(0, 8191));
        it.neighbor_id = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    // Present one item and hold it until accepted.
    task automatic send_item(item_t it);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= it.action;
        vertex_id <= it.vertex_id;
        adjacency_start <= it.adjacency_start;
        vertex_degree <= it.vertex_degree;
        entry_index <= it.entry_index;
        neighbor_id <= it.neighbor_id;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        sb.note_item(it);
        items_sent++;
        if (it.action == ACT_COMPUTE)
            computes_sent++;
    endtask

    task automatic send_query(int vid);
        item_t it;
        it = noise_item(ACT_QUERY);
        it.vertex_id = 10'(vid);
        send_item(it);
    endtask

    // Drop valid and wait until every result is back and the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write vertex_count through the register port; call only when idle.
    task automatic write_vertex_count(int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_VERTEX_COUNT;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.vertex_total = value & 32'h7FF;
    endtask

    // Load a random graph of n vertices in shuffled order, then compute and query.
    task automatic run_graph(int n, int max_deg, int zero_pct, int queries);
        item_t loads[$];
        item_t it;
        int base;
        int p;
        int d;
        int r;
        int last;
        base = $urandom_range(0, 8191 - n * (max_deg + 2));
        p = base;
        last = 0;
        for (int v = 0; v < n; v++)
        begin
            d = ($urandom_range(99) < zero_pct) ? 0 : $urandom_range(1, max_deg);
            it = noise_item(ACT_LOAD_VERTEX);
            it.vertex_id = 10'(v);
            it.adjacency_start = 14'(p);
            it.vertex_degree = 10'(d);
            loads.push_back(it);
            for (int k = 0; k < d; k++)
            begin
                it = noise_item(ACT_LOAD_ADJ);
                it.entry_index = 13'(p + k);
                r = $urandom_range(99);
                if (r < 80)
                    it.neighbor_id = 10'($urandom_range(0, n - 1));
                else if (r < 88)
                    it.neighbor_id = 10'(v);
                else if (r < 94)
                    it.neighbor_id = 10'(last);
                last = it.neighbor_id;
                loads.push_back(it);
            end
            p += d + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0);
        end
        // add stray loads that the compute never reads
        repeat ($urandom_range(0, 3))
        begin
            it = noise_item(ACT_LOAD_ADJ);
            r = p + $urandom_range(0, 40);
            it.entry_index = 13'((r > MAX_ADJ - 1) ? MAX_ADJ - 1 : r);
            loads.push_back(it);
            if (n < MAX_VERTICES)
            begin
                it = noise_item(ACT_LOAD_VERTEX);
                it.vertex_id = 10'($urandom_range(n, 1023));
                loads.push_back(it);
            end
        end
        loads.shuffle();
        foreach (loads[i])
            send_item(loads[i]);
        send_item(noise_item(ACT_COMPUTE));
        repeat (queries)
            send_query(($urandom_range(9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, n - 1));
        // repeat the compute now and then; degrees are unchanged by it
        if ($urandom_range(4) == 0)
        begin
            send_item(noise_item(ACT_COMPUTE));
            send_query($urandom_range(0, n - 1));
        end
    endtask

    initial
    begin
        item_t it;
        int mode;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single vertex of the largest degree; its entries lie past the store.
        it = noise_item(ACT_LOAD_VERTEX);
        it.vertex_id = '0;
        it.adjacency_start = 14'd8192;
        it.vertex_degree = 10'd1023;
        send_item(it);
        send_item(noise_item(ACT_COMPUTE));
        send_query(0);
        send_query(1);
        send_query(1023);
        drain();

        // No vertices in use: nothing peels.
        write_vertex_count(0);
        send_item(noise_item(ACT_COMPUTE));
        send_query(0);
        drain();

        // Triangle 0-1-2 with pendant 3, whose second entry is a neighbor beyond the
        // vertex count; vertex 4 is isolated.
        write_vertex_count(5);
        begin
            int starts[5] = '{0, 2, 4, 7, 9};
            int degs[5] = '{2, 2, 3, 2, 0};
            int nbrs[9] = '{1, 2, 0, 2, 0, 1, 3, 2, 3};
            foreach (starts[v])
            begin
                it = noise_item(ACT_LOAD_VERTEX);
                it.vertex_id = 10'(v);
                it.adjacency_start = 14'(starts[v]);
                it.vertex_degree = 10'(degs[v]);
                send_item(it);
            end
            foreach (nbrs[e])
            begin
                it = noise_item(ACT_LOAD_ADJ);
                it.entry_index = 13'(e);
                it.neighbor_id = 10'((e == 8) ? 700 : nbrs[e]);
                send_item(it);
            end
        end
        send_item(noise_item(ACT_COMPUTE));
        for (int v = 0; v < 6; v++)
            send_query(v);
        drain();

        // Largest vertex count, then a count past the limit on the same graph.
        set_mode(1);
        write_vertex_count(MAX_VERTICES);
        run_graph(MAX_VERTICES, 4, 90, 6);
        drain();
        set_mode(3);
        write_vertex_count(2047);
        send_item(noise_item(ACT_COMPUTE));
        send_query(1023);
        send_query(0);
        drain();

        // Random small graphs, rotating through the idling modes.
        mode = 0;
        while (items_sent < 1850)
        begin
            set_mode(mode);
            mode++;
            begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 150)
                                             : $urandom_range(1, 30);
                write_vertex_count(n);
                run_graph(n, $urandom_range(1, 7), $urandom_range(0, 30),
                          $urandom_range(3, 12));
            end
            drain();
        end

        $display("Sent %0d items in %0d computes; checked %0d results.",
                 items_sent, computes_sent, sb.checked);
        if (sb.errors == 0 && sb.awaited_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #30000000;
        $display("Timed out with %0d results awaited.", sb.awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/kcp_pkg.sv
rtl/kcp_ram.sv
rtl/kcp_engine.sv
rtl/k_core_peeling_order_top.sv
bench/k_core_peeling_order_top_tb.sv
